@@ sv/swts_pkg.sv @@
package swts_pkg;

  localparam int NUM_SYMBOLS = 64;
  localparam int WINDOW_MAX  = 32;
  localparam int SYM_W       = $clog2(NUM_SYMBOLS);
  localparam int SLOT_W      = $clog2(WINDOW_MAX);
  localparam int RING_AW     = SYM_W + SLOT_W;

  localparam int DIV_W       = 80;
  localparam int DEN_W       = 32;
  localparam int SQRT_W      = 64;

  localparam logic [5:0] WINDOW_RESET = 6'd20;
  localparam logic [7:0] SPIKE_RESET  = 8'd18;
  localparam logic [5:0] WINDOW_LOW   = 6'd2;
  localparam logic [5:0] WINDOW_HIGH  = 6'(WINDOW_MAX);

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_SPIKE  = 1'b1;

  typedef struct packed {
    logic [5:0]        fill;
    logic [SLOT_W-1:0] wslot;
    logic [28:0]       s1;
    logic [52:0]       s2;
    logic [52:0]       pv;
    logic [28:0]       vs;
  } rec_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_REC, ST_EVICT,
    ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_MUL5,
    ST_MUL6, ST_MUL7, ST_MUL8, ST_MUL9, ST_MUL10,
    ST_CMP, ST_DIV_GO, ST_DIV_WAIT, ST_SQRT_GO, ST_SQRT_WAIT, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    DIV_VWAP, DIV_VAR, DIV_PCT, DIV_AVG
  } div_op_t;

endpackage

@@ sv/sliding_window_trade_stats.sv @@
// Each accepted tick passes through record read, eviction and the shared multiplies, four divider
// passes (80 bit steps plus start and finish), a square root and an output state. A tick that
// leaves fewer than two in its window stops after the compare and gives no result. A new tick
// is taken only once the last one is through its output state; in_tready is high
// only while idle, and a result still waiting in the output register holds the next tick there.
// Reset (synchronous, rst_n low) clears control and valid bits, loads window 20, spike 18.
module sliding_window_trade_stats import swts_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // symbol_index[5:0], price[29:6], volume[53:30], timestamp[101:54], zero pad
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_symbol[5:0], out_timestamp[53:6], vwap[85:54], volatility[117:86],
  // pct_chg[149:118], avg_vol[181:150], vol_spike[182],
  // window_fill[188:183], zero pad
  output logic [191:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  state_t state_r, state_nxt;

  logic [5:0]  window_len_r;
  logic [7:0]  spike_tenths_r;
  logic        started_r;
  logic [5:0]  wr_len;

  logic [SYM_W-1:0] in_sym;
  logic             in_acc;

  logic [SYM_W-1:0] sym_r;
  logic [23:0]      price_r;
  logic [23:0]      vol_r;
  logic [47:0]      ts_r;

  rec_t             rec_mem [NUM_SYMBOLS];
  rec_t             rec_rd_r;
  rec_t             rec_cur;
  rec_t             rec_r;
  logic [NUM_SYMBOLS-1:0] rec_vld_r;
  logic             rec_hit_r;
  logic             rec_we;

  logic [47:0]        ring_mem [NUM_SYMBOLS*WINDOW_MAX];
  logic [47:0]        ring_rd_r;
  logic               ring_re;
  logic               ring_we;
  logic [SLOT_W-1:0]  ring_rslot;
  logic [SLOT_W-1:0]  slot_clamp;
  logic [SLOT_W-1:0]  oldest_slot;

  logic        evict;
  logic [23:0] op_r, ov_r;
  logic [23:0] first;
  logic [23:0] pdiff;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_r;
  logic [63:0] sq_r, lo_r, d_r, pnum_r, lhs_r;
  logic        neg_r;
  logic        spike_r;
  logic [9:0]  nn1_r;
  logic [11:0] nn1_full;
  logic [8:0]  n10;

  div_op_t          div_op_r;
  logic             div_start;
  logic [DIV_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic             sqrt_start;
  logic             sqrt_done;
  logic [31:0]      sqrt_root;
  logic [63:0]      var_r;
  logic [31:0]      vwap_r, pct_r, avg_r;

  logic         out_valid_r;
  logic [191:0] out_data_r;
  logic         out_load;

  assign in_sym    = in_tdata[5:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign wr_len = (cfg_pwdata[5:0] < WINDOW_LOW)  ? WINDOW_LOW :
                  (cfg_pwdata[5:0] > WINDOW_HIGH) ? WINDOW_HIGH : cfg_pwdata[5:0];
  assign cfg_prdata = (cfg_paddr[2] == REG_SPIKE) ? {24'd0, spike_tenths_r}
                                                  : {26'd0, window_len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r   <= WINDOW_RESET;
      spike_tenths_r <= SPIKE_RESET;
      started_r      <= 1'b0;
    end else begin
      if (in_acc) started_r <= 1'b1;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_WINDOW) begin
          // The window length is frozen once the first tick has arrived.
          if (!started_r) window_len_r <= wr_len;
        end else begin
          spike_tenths_r <= cfg_pwdata[7:0];
        end
      end
    end
  end

  // Per-symbol record memory; a symbol never written reads as all zeros.
  assign rec_we  = (state_r == ST_MUL6);
  assign rec_cur = rec_hit_r ? rec_rd_r : '0;

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[sym_r] <= rec_r;
    if (in_acc) rec_rd_r <= rec_mem[in_sym];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_vld_r <= '0;
      rec_hit_r <= 1'b0;
    end else begin
      if (in_acc) rec_hit_r <= rec_vld_r[in_sym];
      if (rec_we) rec_vld_r[sym_r] <= 1'b1;
    end
  end

  // Tick ring: price in the upper half, volume in the lower half.
  assign slot_clamp  = ({1'b0, rec_cur.wslot} >= window_len_r) ? '0 : rec_cur.wslot;
  assign oldest_slot = (rec_r.fill == window_len_r) ? rec_r.wslot : '0;
  assign ring_re     = (state_r == ST_RD_REC) || (state_r == ST_MUL6);
  assign ring_rslot  = (state_r == ST_RD_REC) ? slot_clamp : oldest_slot;
  assign ring_we     = (state_r == ST_EVICT);

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[{sym_r, rec_r.wslot}] <= {price_r, vol_r};
    if (ring_re) ring_rd_r <= ring_mem[{sym_r, ring_rslot}];
  end

  assign evict = (rec_r.fill >= window_len_r);
  assign first = ring_rd_r[47:24];
  assign pdiff = (price_r >= first) ? (price_r - first) : (first - price_r);
  assign n10   = {rec_r.fill, 3'b000} + {2'b00, rec_r.fill, 1'b0};
  assign nn1_full = 12'(rec_r.fill) * 12'(rec_r.fill - 6'd1);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL1:  begin mul_a = {8'd0, op_r};        mul_b = {8'd0, op_r};         end
      ST_MUL2:  begin mul_a = {8'd0, op_r};        mul_b = {8'd0, ov_r};         end
      ST_MUL3:  begin mul_a = {8'd0, price_r};     mul_b = {8'd0, price_r};      end
      ST_MUL4:  begin mul_a = {8'd0, price_r};     mul_b = {8'd0, vol_r};        end
      ST_MUL5:  begin mul_a = {3'd0, rec_r.s1};    mul_b = {3'd0, rec_r.s1};     end
      ST_MUL6:  begin mul_a = {26'd0, rec_r.fill}; mul_b = rec_r.s2[31:0];       end
      ST_MUL7:  begin mul_a = {26'd0, rec_r.fill}; mul_b = {11'd0, rec_r.s2[52:32]}; end
      ST_MUL8:  begin mul_a = {8'd0, pdiff};       mul_b = 32'd25600;            end
      ST_MUL9:  begin mul_a = {8'd0, vol_r};       mul_b = {23'd0, n10};         end
      ST_MUL10: begin mul_a = {3'd0, rec_r.vs};    mul_b = {24'd0, spike_tenths_r}; end
      default:  begin mul_a = '0;                  mul_b = '0;                   end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // Divider operand selection.
  always_comb begin
    case (div_op_r)
      DIV_VWAP: begin
        div_num = {19'd0, rec_r.pv, 8'd0};
        div_den = {3'd0, rec_r.vs};
      end
      DIV_VAR: begin
        div_num = {d_r, 16'd0};
        div_den = {22'd0, nn1_r};
      end
      DIV_PCT: begin
        div_num = {16'd0, pnum_r};
        div_den = {8'd0, first};
      end
      default: begin
        div_num = {43'd0, rec_r.vs, 8'd0};
        div_den = {26'd0, rec_r.fill};
      end
    endcase
  end

  assign div_start  = (state_r == ST_DIV_GO);
  assign sqrt_start = (state_r == ST_SQRT_GO);

  swts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  swts_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .x     (var_r),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_acc) state_nxt = ST_RD_REC;
      ST_RD_REC:    state_nxt = ST_EVICT;
      ST_EVICT:     state_nxt = ST_MUL1;
      ST_MUL1:      state_nxt = ST_MUL2;
      ST_MUL2:      state_nxt = ST_MUL3;
      ST_MUL3:      state_nxt = ST_MUL4;
      ST_MUL4:      state_nxt = ST_MUL5;
      ST_MUL5:      state_nxt = ST_MUL6;
      ST_MUL6:      state_nxt = ST_MUL7;
      ST_MUL7:      state_nxt = ST_MUL8;
      ST_MUL8:      state_nxt = ST_MUL9;
      ST_MUL9:      state_nxt = ST_MUL10;
      ST_MUL10:     state_nxt = ST_CMP;
      ST_CMP:       state_nxt = (rec_r.fill < 6'd2) ? ST_IDLE : ST_DIV_GO;
      ST_DIV_GO:    state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_nxt = (div_op_r == DIV_AVG) ? ST_SQRT_GO : ST_DIV_GO;
      ST_SQRT_GO:   state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (sqrt_done) state_nxt = ST_OUT;
      ST_OUT:       if (out_load) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_op_r    <= DIV_VWAP;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CMP) div_op_r <= DIV_VWAP;
      else if ((state_r == ST_DIV_WAIT) && div_done) div_op_r <= div_op_t'(div_op_r + 2'd1);
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sym_r   <= in_sym;
          price_r <= in_tdata[29:6];
          vol_r   <= in_tdata[53:30];
          ts_r    <= in_tdata[101:54];
        end
      end
      ST_RD_REC: begin
        rec_r <= '{rec_cur.fill, slot_clamp, rec_cur.s1, rec_cur.s2, rec_cur.pv, rec_cur.vs};
      end
      ST_EVICT: begin
        op_r <= evict ? ring_rd_r[47:24] : 24'd0;
        ov_r <= evict ? ring_rd_r[23:0] : 24'd0;
        rec_r.s1 <= rec_r.s1 - (evict ? 29'(ring_rd_r[47:24]) : 29'd0) + 29'(price_r);
        rec_r.vs <= rec_r.vs - (evict ? 29'(ring_rd_r[23:0]) : 29'd0) + 29'(vol_r);
        rec_r.fill <= evict ? window_len_r : rec_r.fill + 6'd1;
        rec_r.wslot <= (({1'b0, rec_r.wslot} + 6'd1) == window_len_r) ? '0
                       : rec_r.wslot + 1'b1;
      end
      ST_MUL2: rec_r.s2 <= rec_r.s2 - mul_r[52:0];
      ST_MUL3: rec_r.pv <= rec_r.pv - mul_r[52:0];
      ST_MUL4: rec_r.s2 <= rec_r.s2 + mul_r[52:0];
      ST_MUL5: rec_r.pv <= rec_r.pv + mul_r[52:0];
      ST_MUL6: sq_r <= mul_r;
      ST_MUL7: lo_r <= mul_r;
      ST_MUL8: begin
        // n*S2 - S1^2, built from the two halves of n*S2.
        d_r   <= {mul_r[31:0], 32'd0} + lo_r - sq_r;
        neg_r <= (price_r < first);
      end
      ST_MUL9:  pnum_r <= mul_r;
      ST_MUL10: lhs_r <= mul_r;
      ST_CMP: begin
        spike_r <= (lhs_r > mul_r);
        nn1_r   <= nn1_full[9:0];
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          case (div_op_r)
            DIV_VWAP: vwap_r <= (rec_r.vs == 29'd0) ? 32'd0 : div_quo[31:0];
            DIV_VAR:  var_r  <= div_quo[63:0];
            DIV_PCT: begin
              if (first == 24'd0)         pct_r <= 32'd0;
              else if (neg_r)             pct_r <= (~div_quo[31:0]) + 32'd1;
              else if (div_quo[79:31] != '0) pct_r <= 32'h7FFF_FFFF;
              else                        pct_r <= div_quo[31:0];
            end
            default:  avg_r  <= div_quo[31:0];
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {3'd0, rec_r.fill, spike_r, avg_r, pct_r, sqrt_root, vwap_r,
                     ts_r, sym_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ sv/swts_div.sv @@
module swts_div import swts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [DIV_W-1:0] quo
);

  logic                     busy_r;
  logic                     done_r;
  logic [$clog2(DIV_W)-1:0] cnt_r;
  logic [DEN_W-1:0]         rem_r;
  logic [DEN_W-1:0]         den_r;
  logic [DIV_W-1:0]         quo_r;
  logic [DEN_W:0]           trial;
  logic [DEN_W:0]           diff;
  logic                     ge;

  // Restoring division, one quotient bit per cycle, numerator shifted in from the top.
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(DIV_W))'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ sv/swts_sqrt.sv @@
module swts_sqrt import swts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQRT_W-1:0] x,
  output logic              done,
  output logic [31:0]       root
);

  logic                        busy_r;
  logic                        done_r;
  logic [$clog2(SQRT_W/2)-1:0] cnt_r;
  logic [SQRT_W-1:0]           x_r;
  logic [SQRT_W-1:0]           r_r;
  logic [SQRT_W-1:0]           bit_r;
  logic [SQRT_W-1:0]           rb;

  // Digit-by-digit square root, two radicand bits per cycle.
  assign rb = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(SQRT_W/2))'(SQRT_W/2 - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      r_r   <= '0;
      bit_r <= {2'b01, {(SQRT_W-2){1'b0}}};
    end else if (busy_r) begin
      if (x_r >= rb) begin
        x_r <= x_r - rb;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule

@@ sv/swts_checker.sv @@
module swts_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [191:0] out_tdata
);

  // A result never shows up right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The block works on one tick at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready again right after accepting a tick");

  // A result always covers at least two ticks and at most a full window.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[188:183] >= 6'd2 && out_tdata[188:183] <= 6'd32))
    else $error("window fill out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind sliding_window_trade_stats swts_checker u_swts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ test/tb_top.sv @@
module tb_top;
  import swts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 400;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [2:0] ADDR_WINDOW = 3'd0;
  localparam logic [2:0] ADDR_SPIKE  = 3'd4;

  typedef struct packed {
    logic [5:0]  sym;
    logic [47:0] ts;
    logic [31:0] vwap;
    logic [31:0] vola;
    logic [31:0] pct;
    logic [31:0] avg_vol;
    logic        spike;
    logic [5:0]  fill;
  } stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [103:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  sliding_window_trade_stats uut (.*);

  always #5 clk = ~clk;

  // Predictor state: per-symbol rings and running sums.
  logic [23:0] price_hist [NUM_SYMBOLS][WINDOW_MAX];
  logic [23:0] vol_hist [NUM_SYMBOLS][WINDOW_MAX];
  int unsigned tick_count [NUM_SYMBOLS];
  int unsigned next_slot [NUM_SYMBOLS];
  logic [63:0] sum_p [NUM_SYMBOLS] = '{default: 64'd0};
  logic [63:0] sum_pp [NUM_SYMBOLS] = '{default: 64'd0};
  logic [63:0] sum_pv [NUM_SYMBOLS] = '{default: 64'd0};
  logic [63:0] sum_v [NUM_SYMBOLS] = '{default: 64'd0};
  int unsigned win_len = 20;
  logic [7:0] spike_thresh = 8'd18;
  bit ticks_seen = 0;

  stats_t pending_stats[$];
  int mismatches = 0;
  longint cycles = 0;
  bit hold_off = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] frac_div(logic [63:0] num, logic [63:0] den, int sh);
    return ((num / den) << sh) + (((num % den) << sh) / den);
  endfunction

  task automatic predict_tick(logic [5:0] s, logic [23:0] p, logic [23:0] v,
                              logic [47:0] ts);
    int unsigned f, w, n, oldest;
    logic [63:0] d, first, mag;
    stats_t r;
    ticks_seen = 1;
    f = tick_count[s];
    w = next_slot[s];
    if (w >= win_len) w = 0;
    if (f >= win_len) begin
      sum_p[s] -= price_hist[s][w];
      sum_pp[s] -= 64'(price_hist[s][w]) * price_hist[s][w];
      sum_pv[s] -= 64'(price_hist[s][w]) * vol_hist[s][w];
      sum_v[s] -= vol_hist[s][w];
      f = win_len;
    end
    price_hist[s][w] = p;
    vol_hist[s][w] = v;
    sum_p[s] += p;
    sum_pp[s] += 64'(p) * p;
    sum_pv[s] += 64'(p) * v;
    sum_v[s] += v;
    w = (w + 1) % win_len;
    if (f < win_len) f++;
    tick_count[s] = f;
    next_slot[s] = w;
    if (f < 2) return;
    n = f;
    r.sym = s;
    r.ts = ts;
    r.vwap = (sum_v[s] != 0) ? 32'(frac_div(sum_pv[s], sum_v[s], 8)) : 32'd0;
    d = 64'(n) * sum_pp[s] - sum_p[s] * sum_p[s];
    r.vola = 32'(int_sqrt(frac_div(d, 64'(n) * 64'(n - 1), 16)));
    oldest = (f == win_len) ? w : 0;
    first = price_hist[s][oldest];
    if (first == 0) begin
      r.pct = 0;
    end else if (p >= first) begin
      mag = (64'(p) - first) * 25600 / first;
      r.pct = (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : 32'(mag);
    end else begin
      mag = (first - p) * 25600 / first;
      r.pct = 32'(-mag);
    end
    r.avg_vol = 32'((sum_v[s] << 8) / n);
    r.spike = (64'(v) * n * 10 > sum_v[s] * spike_thresh);
    r.fill = 6'(n);
    pending_stats = {pending_stats, r};
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    logic [5:0] v;
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == ADDR_WINDOW) begin
      v = data[5:0];
      if (!ticks_seen) win_len = (v < 2) ? 2 : (v > WINDOW_MAX) ? WINDOW_MAX : v;
    end else begin
      spike_thresh = data[7:0];
    end
  endtask

  // The valid line stays up after a request is taken; the next call either drops it for
  // its idle gap or presents new data at once, and drain drops it at the end of a burst.
  task automatic send_tick(logic [5:0] s, logic [23:0] p, logic [23:0] v,
                           logic [47:0] ts, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b0, ts, v, p, s};
    do @(posedge clk); while (!in_tready);
    predict_tick(s, p, v, ts);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Result side: random stalls, or a long hold-off when requested.
  initial begin
    int gap;
    forever begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0 || hold_off) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    stats_t got, want;
    if (out_tvalid && out_tready) begin
      got = {out_tdata[5:0], out_tdata[53:6], out_tdata[85:54], out_tdata[117:86],
             out_tdata[149:118], out_tdata[181:150], out_tdata[182],
             out_tdata[188:183]};
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_stats[0];
        pending_stats.delete(0);
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_config_extremes();
    reg_write(ADDR_WINDOW, 32'd1);   // below range, clamps to 2
    reg_write(ADDR_WINDOW, 32'd63);  // above range, clamps to the maximum
    reg_write(ADDR_WINDOW, 32'd3);
    reg_write(ADDR_SPIKE, 32'd0);
  endtask

  task automatic test_directed();
    send_tick(6'd0, 24'd0, 24'd0, 48'd0);
    send_tick(6'd0, 24'd100, 24'd0, 48'hFFFFFFFFFFFF);   // oldest price zero
    send_tick(6'd1, 24'hFFFFFF, 24'hFFFFFF, 48'd5);
    send_tick(6'd1, 24'hFFFFFF, 24'hFFFFFF, 48'd6);
    send_tick(6'd1, 24'hFFFFFF, 24'hFFFFFF, 48'd7);      // window fills
    send_tick(6'd2, 24'd1, 24'd10, 48'd8);
    send_tick(6'd2, 24'hFFFFFF, 24'd1, 48'd9);           // saturating rise
    send_tick(6'd2, 24'd1, 24'hFFFFFF, 48'd10);          // no change, spike
    send_tick(6'd63, 24'd500, 24'd0, 48'd11);
    send_tick(6'd63, 24'd0, 24'd0, 48'd12);              // zero volume sum
    send_tick(6'd63, 24'd200, 24'd3, 48'd13);
    drain();
    reg_write(ADDR_WINDOW, 32'd32);  // ignored after start
    reg_write(ADDR_SPIKE, 32'd255);
    send_tick(6'd3, 24'd1000, 24'd50, 48'd14);
    send_tick(6'd3, 24'd1010, 24'd60, 48'd15);
    drain();
  endtask

  task automatic test_random(int count);
    logic [23:0] p, v;
    logic [5:0] s;
    repeat (count) begin
      s = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
      case ($urandom_range(0, 3))
        0: p = 24'($urandom);
        1: p = 24'($urandom_range(0, 3));
        default: p = 24'($urandom_range(9000, 11000));
      endcase
      v = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 500));
      send_tick(s, p, v, {16'($urandom), 32'($urandom)});
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    fork
      begin
        repeat (2000) @(posedge clk);
        hold_off = 0;
      end
      test_random(8);
    join
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_config_extremes();
    test_directed();
    test_random(260);
    test_backpressure();
    reg_write(ADDR_SPIKE, 32'd18);
    test_random(260);
    drain();
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
sv/swts_pkg.sv
sv/swts_div.sv
sv/swts_sqrt.sv
sv/sliding_window_trade_stats.sv
sv/swts_checker.sv
test/tb_top.sv
